/* hw/rtl/bvis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvis_pkg
// Shared constants and types of the bounded vector insert stack.
// ----------------------------------------------------------------------------
package bvis_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int SLOT_W   = 7;
	localparam int ENTRY_W  = 7;
	localparam int CMP_W    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic [1:0] {
		CMD_PUSH   = 2'd0,
		CMD_POP    = 2'd1,
		CMD_INSERT = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_ZERO   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_BADPOS = 3'd3,
		ST_FULL   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		K_NONE,
		K_INSERT,
		K_POP
	} kind_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		kind_t kind;
		cnt_t  pos;
		data_t word;
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/bvis_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvis_cmd_if / bvis_res_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface bvis_cmd_if;
	import bvis_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          command;
	logic signed [31:0]  item_value;
	logic [SLOT_W-1:0]   slot;
	modport source (output valid, command, item_value, slot, input ready);
	modport sink (input valid, command, item_value, slot, output ready);
endinterface

interface bvis_res_if;
	import bvis_pkg::*;
	logic                valid;
	logic                ready;
	logic signed [31:0]  popped_value;
	logic [2:0]          status;
	logic [ENTRY_W-1:0]  entry_count;
	modport source (output valid, popped_value, status, entry_count, input ready);
	modport sink (input valid, popped_value, status, entry_count, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bvis_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvis_cell
// One storage cell of the chain; cell 0 holds the newest entry.
// ----------------------------------------------------------------------------
module bvis_cell (
	input  wire logic                clk,
	input  wire bvis_pkg::cnt_t      idx,
	input  wire bvis_pkg::cell_ctrl_t ctrl,
	input  wire bvis_pkg::data_t     from_lower,
	input  wire bvis_pkg::data_t     from_upper,
	output bvis_pkg::data_t          data
);
	import bvis_pkg::*;

	data_t data_q;
	data_t data_nxt;

	always_comb begin
		data_nxt = data_q;
		unique case (ctrl.kind)
			K_INSERT: begin
				if (idx == ctrl.pos) begin
					data_nxt = ctrl.word;
				end else if (idx > ctrl.pos) begin
					data_nxt = from_lower;
				end
			end
			K_POP: begin
				data_nxt = from_upper;
			end
			default: begin
				data_nxt = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;

endmodule
`default_nettype wire

/* hw/rtl/bounded_vector_insert_stack_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_vector_insert_stack_top
// Bounded ordered list with push, pop and positional insert.
// ----------------------------------------------------------------------------
// Each command transaction yields one result transaction in the cycle after it
// is taken, and a new command is taken every cycle while the result side
// keeps up. Entries live in a chain of cells with the newest entry in cell 0;
// pop shifts the whole chain toward cell 0, while push and insert shift the
// cells from the broadcast insert point up, each cell comparing its own index against that point.
// ----------------------------------------------------------------------------
module bounded_vector_insert_stack_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bvis_cmd_if.sink   cmd,
	bvis_res_if.source res
);
	import bvis_pkg::*;

	cnt_t       count_q;
	cnt_t       cnt_nxt;
	logic       res_valid_q;
	data_t      popped_q;
	status_t    status_q;
	cnt_t       count_out_q;
	data_t      cell_data [CAPACITY];
	cell_ctrl_t ctrl;
	kind_t      kind;
	cnt_t       pos;
	status_t    status;
	data_t      popped;
	logic       accept;
	logic       full;
	logic       is_zero;
	logic [CMP_W-1:0] slot_c;
	logic [CMP_W-1:0] cnt_c;

	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign is_zero   = (cmd.item_value == '0);
	assign slot_c    = CMP_W'(cmd.slot);
	assign cnt_c     = CMP_W'(count_q);

	always_comb begin
		status  = ST_OK;
		kind    = K_NONE;
		pos     = '0;
		cnt_nxt = count_q;
		popped  = '0;
		unique case (cmd.command)
			CMD_PUSH: begin
				if (is_zero) begin
					status = ST_ZERO;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					kind    = K_INSERT;
					cnt_nxt = count_q + cnt_t'(1);
				end
			end
			CMD_POP: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					kind    = K_POP;
					popped  = cell_data[0];
					cnt_nxt = count_q - cnt_t'(1);
				end
			end
			CMD_INSERT: begin
				if (slot_c > cnt_c) begin
					status = ST_BADPOS;
				end else if (slot_c == cnt_c && is_zero) begin
					status = ST_ZERO;
				end else if (full) begin
					status = ST_FULL;
				end else begin
					kind    = K_INSERT;
					pos     = CNT_W'(cnt_c - slot_c);
					cnt_nxt = count_q + cnt_t'(1);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	always_comb begin
		ctrl.kind = accept ? kind : K_NONE;
		ctrl.pos  = pos;
		ctrl.word = cmd.item_value;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bvis_cell u_cell (
			.clk        (clk),
			.idx        (CNT_W'(i)),
			.ctrl       (ctrl),
			.from_lower ((i == 0) ? cmd.item_value : cell_data[(i == 0) ? 0 : i - 1]),
			.from_upper ((i == CAPACITY - 1) ? cell_data[i]
				: cell_data[(i == CAPACITY - 1) ? i : i + 1]),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= cnt_nxt;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q    <= popped;
			status_q    <= status;
			count_out_q <= cnt_nxt;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.popped_value = popped_q;
	assign res.status       = status_q;
	assign res.entry_count  = ENTRY_W'(count_out_q);

endmodule
`default_nettype wire
